### rtl/crcm_pkg.sv
// Shared constants, types and pooled-map tables for the conv/ReLU/clamp/maxpool block.
// Image and kernel geometry are fixed here; every module takes this package in.
// No dependencies.
package crcm_pkg;

   localparam int IMG_W        = 28;
   localparam int IMG_H        = 28;
   localparam int KERNEL       = 3;
   localparam int MAX_CHANNELS = 8;
   localparam int POOL         = 2;

   localparam int WDEPTH = MAX_CHANNELS * KERNEL * KERNEL;
   localparam int IDEPTH = MAX_CHANNELS * IMG_W * IMG_H;
   localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
   localparam int IAW    = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;

   localparam int IDX_W = 13;
   localparam int VAL_W = 16;
   localparam int OUT_W = 15;

   localparam int DIM_MAX   = (IMG_W > IMG_H) ? IMG_W : IMG_H;
   localparam int DIM_W     = $clog2(DIM_MAX) + 1;
   localparam int CH_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int K_W       = (KERNEL > 1) ? $clog2(KERNEL) : 1;
   localparam int ACC_W     = 2 * VAL_W + $clog2(WDEPTH + 1) + 1;
   localparam int DIV_CNT_W = $clog2(IDX_W + 1);

   localparam logic [1:0] MODE_WEIGHT = 2'd0;
   localparam logic [1:0] MODE_PIXEL  = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;

   localparam logic [1:0] CSR_STRIDE   = 2'd0;
   localparam logic [1:0] CSR_CHANNELS = 2'd1;
   localparam logic [1:0] CSR_BIAS     = 2'd2;
   localparam logic [1:0] CSR_CLAMP    = 2'd3;

   // pooled map width and height for each stride
   localparam int PW_S1 = (IMG_W < KERNEL) ? 0 : ((IMG_W - KERNEL) / 1 + 1) / POOL;
   localparam int PW_S2 = (IMG_W < KERNEL) ? 0 : ((IMG_W - KERNEL) / 2 + 1) / POOL;
   localparam int PW_S3 = (IMG_W < KERNEL) ? 0 : ((IMG_W - KERNEL) / 3 + 1) / POOL;
   localparam int PW_S4 = (IMG_W < KERNEL) ? 0 : ((IMG_W - KERNEL) / 4 + 1) / POOL;
   localparam int PH_S1 = (IMG_H < KERNEL) ? 0 : ((IMG_H - KERNEL) / 1 + 1) / POOL;
   localparam int PH_S2 = (IMG_H < KERNEL) ? 0 : ((IMG_H - KERNEL) / 2 + 1) / POOL;
   localparam int PH_S3 = (IMG_H < KERNEL) ? 0 : ((IMG_H - KERNEL) / 3 + 1) / POOL;
   localparam int PH_S4 = (IMG_H < KERNEL) ? 0 : ((IMG_H - KERNEL) / 4 + 1) / POOL;

   typedef logic [DIM_W-1:0] dim_type;

   function automatic dim_type pool_w(input logic [2:0] st);
      case (st)
         3'd2:    return DIM_W'(PW_S2);
         3'd3:    return DIM_W'(PW_S3);
         3'd4:    return DIM_W'(PW_S4);
         default: return DIM_W'(PW_S1);
      endcase
   endfunction

   function automatic dim_type pool_h(input logic [2:0] st);
      case (st)
         3'd2:    return DIM_W'(PH_S2);
         3'd3:    return DIM_W'(PH_S3);
         3'd4:    return DIM_W'(PH_S4);
         default: return DIM_W'(PH_S1);
      endcase
   endfunction

   typedef struct packed {
      logic    done;
      dim_type quot;
      dim_type rem;
   } div_result_type;

   typedef struct packed {
      logic clear;
      logic valid;
   } mac_ctrl_type;

   typedef struct packed {
      logic             w_we;
      logic [WAW-1:0]   w_addr;
      logic             i_we;
      logic [IAW-1:0]   i_addr;
      logic [VAL_W-1:0] data;
   } store_wr_type;

endpackage

### rtl/crcm_div.sv
// Restoring divider, one quotient bit per cycle: splits a pooled position into row and column.
// Depends on crcm_pkg.
module crcm_div
   import crcm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [IDX_W-1:0]     dividend,
   input  dim_type              divisor,
   output div_result_type       result
);

   logic [DIM_W:0]     rem_ff, rem_in;
   logic [IDX_W-1:0]   quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DIM_W:0]     shifted;

   always_comb begin
      shifted = {rem_ff[DIM_W-1:0], quo_ff[IDX_W-1]};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = DIV_CNT_W'(IDX_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[IDX_W-2:0], 1'b0};
         if (shifted >= {1'b0, divisor}) begin
            rem_in    = shifted - {1'b0, divisor};
            quo_in[0] = 1'b1;
         end else begin
            rem_in = shifted;
         end
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign result.done = done_ff;
   assign result.quot = quo_ff[DIM_W-1:0];
   assign result.rem  = rem_ff[DIM_W-1:0];

endmodule

### rtl/crcm_store.sv
// Weight and image stores: one write port and one registered read port each.
// Depends on crcm_pkg.
module crcm_store
   import crcm_pkg::*;
(
   input  logic             clock,
   input  store_wr_type     wr,
   input  logic [WAW-1:0]   rd_w_addr,
   input  logic [IAW-1:0]   rd_i_addr,
   output logic [VAL_W-1:0] w_data,
   output logic [VAL_W-1:0] i_data
);

   logic [VAL_W-1:0] wmem [WDEPTH];
   logic [VAL_W-1:0] imem [IDEPTH];
   logic [VAL_W-1:0] w_data_ff;
   logic [VAL_W-1:0] i_data_ff;

   always_ff @(posedge clock) begin
      if (wr.w_we) begin
         wmem[wr.w_addr] <= wr.data;
      end
      w_data_ff <= wmem[rd_w_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.i_we) begin
         imem[wr.i_addr] <= wr.data;
      end
      i_data_ff <= imem[rd_i_addr];
   end

   assign w_data = w_data_ff;
   assign i_data = i_data_ff;

endmodule

### rtl/crcm_mac.sv
// Shared multiply-accumulate unit: registered 16x16 product, then a wide accumulator.
// Depends on crcm_pkg.
module crcm_mac
   import crcm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  mac_ctrl_type            ctrl,
   input  logic signed [VAL_W-1:0] bias,
   input  logic signed [VAL_W-1:0] weight,
   input  logic signed [VAL_W-1:0] pixel,
   output logic signed [ACC_W-1:0] acc
);

   logic signed [2*VAL_W-1:0] prod_ff;
   logic                      prod_vld_ff;
   logic signed [ACC_W-1:0]   acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= weight * pixel;
      // seed with bias in Q16.16
      if (ctrl.clear) begin
         acc_ff <= ACC_W'(bias) <<< 8;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   assign acc = acc_ff;

endmodule

### rtl/conv_relu_clamp_maxpool.sv
// One conv filter with ReLU, upper clamp and 2x2 max pooling, one pooled output per query.
// Top level: sequencer, configuration registers and result register.
// Depends on crcm_pkg, crcm_div, crcm_store, crcm_mac.
//
// Usage. Request beats carry mode in req_tuser: weight load, pixel load or query.
// Loads write the kernel or channel-planar image store and give no response beat.
// A query names a pooled position; one response beat returns the pooled value in
// rsp_tdata and the out-of-map flag in rsp_tuser.
// A query runs the divider for row and column, then
// for each of the four pooling windows one multiply-accumulate per tap on the
// shared MAC. An out-of-map query goes from the range check straight to the
// response. The MAC pipeline (store read, product, accumulate) is drained
// after the last tap of each window, before its ReLU and clamp.
// req_tready is high only while the sequencer is idle. A finished result waits in
// the output register; loads are still taken while it waits, and a later query
// holds at its end until rsp_tready frees the register.
// Reset (synchronous) returns the registers to stride 1, one channel, bias 0 and
// clamp 10.0, and empties the response register; the stores are not cleared.
// csr_we writes csr_wdata into register csr_addr at any clock edge outside reset.
module conv_relu_clamp_maxpool
   import crcm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // index[12:0], value[28:13], zero pad
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // pooled_value[14:0], zero pad
   output logic [0:0]  rsp_tuser,   // index_error[0]
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CHECK = 4'd1;
   localparam logic [3:0] ST_DIV   = 4'd2;
   localparam logic [3:0] ST_WIN   = 4'd3;
   localparam logic [3:0] ST_ADDR  = 4'd4;
   localparam logic [3:0] ST_RUN   = 4'd5;
   localparam logic [3:0] ST_DRAIN = 4'd6;
   localparam logic [3:0] ST_FIN   = 4'd7;
   localparam logic [3:0] ST_RESP  = 4'd8;

   localparam int PA_ROW_STEP = IMG_W - (KERNEL - 1);
   localparam int PA_CH_STEP  = IMG_W * IMG_H - (KERNEL - 1) * IMG_W - (KERNEL - 1);
   localparam int CMP_W       = 2 * DIM_W + IDX_W;
   localparam logic [K_W-1:0] K_LAST = K_W'(KERNEL - 1);

   logic [2:0]        stride_ff;
   logic [3:0]        chan_ff;
   logic [VAL_W-1:0]  bias_ff;
   logic [OUT_W-1:0]  clamp_ff;

   logic [3:0]        state_ff, state_in;
   logic [IDX_W-1:0]  q_idx_ff, q_idx_in;
   dim_type           i_ff, i_in, j_ff, j_in;
   logic              dy_ff, dy_in, dx_ff, dx_in;
   dim_type           y_base_ff, y_base_in, x_base_ff, x_base_in;
   logic [IAW-1:0]    pa_ff, pa_in;
   logic [WAW-1:0]    wa_ff, wa_in;
   logic [CH_W-1:0]   ch_ff, ch_in;
   logic [K_W-1:0]    ky_ff, ky_in, kx_ff, kx_in;
   logic              rd_vld_ff;
   logic              drain_ff, drain_in;
   logic [OUT_W-1:0]  best_ff, best_in;
   logic              err_ff, err_in;
   logic              rsp_vld_ff, rsp_vld_in;
   logic [OUT_W-1:0]  rsp_val_ff, rsp_val_in;
   logic              rsp_err_ff, rsp_err_in;

   logic              req_accept;
   logic [IDX_W-1:0]  req_idx;
   logic [VAL_W-1:0]  req_val;
   logic [2:0]        st_eff;
   logic [CH_W-1:0]   ch_last;
   dim_type           pw, ph;
   logic [2*DIM_W-1:0] pcount;
   dim_type           r_row, c_col;
   logic [DIM_W+2:0]  y_prod, x_prod;
   logic [OUT_W+7:0]  lim;
   logic [OUT_W-1:0]  win_val;
   logic              rsp_load;
   logic              div_start;

   store_wr_type      store_wr;
   mac_ctrl_type      mac_ctrl;
   div_result_type    div_res;
   logic [VAL_W-1:0]  w_rd, i_rd;
   logic signed [ACC_W-1:0] acc;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_idx    = req_tdata[IDX_W-1:0];
   assign req_val    = req_tdata[IDX_W+VAL_W-1:IDX_W];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff <= 3'd1;
         chan_ff   <= 4'd1;
         bias_ff   <= '0;
         clamp_ff  <= OUT_W'(2560);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_STRIDE:   stride_ff <= csr_wdata[2:0];
            CSR_CHANNELS: chan_ff   <= csr_wdata[3:0];
            CSR_BIAS:     bias_ff   <= csr_wdata;
            CSR_CLAMP:    clamp_ff  <= csr_wdata[OUT_W-1:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      if (stride_ff == 3'd0) begin
         st_eff = 3'd1;
      end else if (stride_ff > 3'd4) begin
         st_eff = 3'd4;
      end else begin
         st_eff = stride_ff;
      end
      if (chan_ff == 4'd0) begin
         ch_last = '0;
      end else if (32'(chan_ff) > MAX_CHANNELS) begin
         ch_last = CH_W'(MAX_CHANNELS - 1);
      end else begin
         ch_last = CH_W'(chan_ff - 4'd1);
      end
   end

   assign pw     = pool_w(st_eff);
   assign ph     = pool_h(st_eff);
   assign pcount = (2*DIM_W)'(pw) * (2*DIM_W)'(ph);

   // conv row and column of the current window, then their image origin
   assign r_row  = DIM_W'({i_ff, dy_ff});
   assign c_col  = DIM_W'({j_ff, dx_ff});
   assign y_prod = (DIM_W+3)'(r_row) * (DIM_W+3)'(st_eff);
   assign x_prod = (DIM_W+3)'(c_col) * (DIM_W+3)'(st_eff);

   // ReLU and clamp of the finished window sum
   always_comb begin
      lim = {clamp_ff, 8'd0};
      if (acc[ACC_W-1] || (acc == '0)) begin
         win_val = '0;
      end else if ($unsigned(acc) > ACC_W'(lim)) begin
         win_val = clamp_ff;
      end else begin
         win_val = acc[OUT_W+7:8];
      end
   end

   always_comb begin
      store_wr.w_we   = req_accept && (req_tuser == MODE_WEIGHT) && (32'(req_idx) < WDEPTH);
      store_wr.w_addr = WAW'(req_idx);
      store_wr.i_we   = req_accept && (req_tuser == MODE_PIXEL) && (32'(req_idx) < IDEPTH);
      store_wr.i_addr = IAW'(req_idx);
      store_wr.data   = req_val;
   end

   always_comb begin
      state_in  = state_ff;
      q_idx_in  = q_idx_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      dy_in     = dy_ff;
      dx_in     = dx_ff;
      y_base_in = y_base_ff;
      x_base_in = x_base_ff;
      pa_in     = pa_ff;
      wa_in     = wa_ff;
      ch_in     = ch_ff;
      ky_in     = ky_ff;
      kx_in     = kx_ff;
      drain_in  = drain_ff;
      best_in   = best_ff;
      err_in    = err_ff;
      rsp_load  = 1'b0;
      div_start = 1'b0;
      mac_ctrl.clear = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_tuser == MODE_QUERY)) begin
               q_idx_in = req_idx;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            best_in = '0;
            if (CMP_W'(q_idx_ff) >= CMP_W'(pcount)) begin
               err_in   = 1'b1;
               state_in = ST_RESP;
            end else begin
               err_in    = 1'b0;
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               i_in     = div_res.quot;
               j_in     = div_res.rem;
               dy_in    = 1'b0;
               dx_in    = 1'b0;
               state_in = ST_WIN;
            end
         end
         ST_WIN: begin
            y_base_in = y_prod[DIM_W-1:0];
            x_base_in = x_prod[DIM_W-1:0];
            state_in  = ST_ADDR;
         end
         ST_ADDR: begin
            pa_in    = IAW'(y_base_ff) * IAW'(IMG_W) + IAW'(x_base_ff);
            wa_in    = '0;
            ch_in    = '0;
            ky_in    = '0;
            kx_in    = '0;
            drain_in = 1'b0;
            mac_ctrl.clear = 1'b1;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            wa_in = wa_ff + WAW'(1);
            if (kx_ff == K_LAST) begin
               kx_in = '0;
               if (ky_ff == K_LAST) begin
                  ky_in = '0;
                  ch_in = ch_ff + CH_W'(1);
                  pa_in = pa_ff + IAW'(PA_CH_STEP);
                  if (ch_ff == ch_last) begin
                     state_in = ST_DRAIN;
                  end
               end else begin
                  ky_in = ky_ff + K_W'(1);
                  pa_in = pa_ff + IAW'(PA_ROW_STEP);
               end
            end else begin
               kx_in = kx_ff + K_W'(1);
               pa_in = pa_ff + IAW'(1);
            end
         end
         ST_DRAIN: begin
            // wait out the read and product stages
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (win_val > best_ff) begin
               best_in = win_val;
            end
            if (!dx_ff) begin
               dx_in    = 1'b1;
               state_in = ST_WIN;
            end else begin
               dx_in = 1'b0;
               if (!dy_ff) begin
                  dy_in    = 1'b1;
                  state_in = ST_WIN;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            // hold until the output register is free
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign mac_ctrl.valid = rd_vld_ff;

   always_comb begin
      rsp_val_in = rsp_val_ff;
      rsp_err_in = rsp_err_ff;
      if (rsp_load) begin
         rsp_vld_in = 1'b1;
         rsp_val_in = best_ff;
         rsp_err_in = err_ff;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rsp_vld_ff <= 1'b0;
         rd_vld_ff  <= 1'b0;
         drain_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
         rd_vld_ff  <= (state_ff == ST_RUN);
         drain_ff   <= drain_in;
      end
   end

   always_ff @(posedge clock) begin
      q_idx_ff   <= q_idx_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      dy_ff      <= dy_in;
      dx_ff      <= dx_in;
      y_base_ff  <= y_base_in;
      x_base_ff  <= x_base_in;
      pa_ff      <= pa_in;
      wa_ff      <= wa_in;
      ch_ff      <= ch_in;
      ky_ff      <= ky_in;
      kx_ff      <= kx_in;
      best_ff    <= best_in;
      err_ff     <= err_in;
      rsp_val_ff <= rsp_val_in;
      rsp_err_ff <= rsp_err_in;
   end

   crcm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (q_idx_ff),
      .divisor  (pw),
      .result   (div_res)
   );

   crcm_store u_store (
      .clock     (clock),
      .wr        (store_wr),
      .rd_w_addr (wa_ff),
      .rd_i_addr (pa_ff),
      .w_data    (w_rd),
      .i_data    (i_rd)
   );

   crcm_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .bias   (bias_ff),
      .weight (w_rd),
      .pixel  (i_rd),
      .acc    (acc)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {1'b0, rsp_val_ff};
   assign rsp_tuser  = rsp_err_ff;

endmodule

### rtl/crcm_checker.sv
// Port-level checks for conv_relu_clamp_maxpool, attached by the bind below.
// Depends on crcm_pkg and the top level's port list.
module crcm_checker
   import crcm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [0:0]  rsp_tuser,
   input logic        csr_we,
   input logic [1:0]  csr_addr,
   input logic [15:0] csr_wdata
);

   // reset empties the response register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response beat pending after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response beat changed");

   // an out-of-map answer carries a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 16'd0)
      else $error("index error beat with nonzero value");

   // a query keeps the request side closed while it runs
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == MODE_QUERY) |=> !req_tready)
      else $error("request taken during a query");

endmodule

bind conv_relu_clamp_maxpool crcm_checker u_checker (.*);

### verif/crcm_pool_checker.sv
// Response checker for conv_relu_clamp_maxpool: mirrors the kernel and image stores and the
// registers from the observed beats and predicts each pooled answer at query acceptance.
// Depends on crcm_pkg.
module crcm_pool_checker
   import crcm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // index[12:0], value[28:13], zero pad
   input  logic [1:0]  req_tuser,   // mode[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // pooled_value[14:0], zero pad
   input  logic [0:0]  rsp_tuser,   // index_error[0]
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata,
   output int          mismatch_count,
   output int          pending_count
);

   typedef struct {
      logic [OUT_W-1:0] pooled;
      logic             out_of_map;
   } pool_result_t;

   logic signed [VAL_W-1:0] kernel_mem [WDEPTH];
   logic signed [VAL_W-1:0] image_mem  [IDEPTH];

   logic [2:0]        stride_reg;
   logic [3:0]        chan_reg;
   logic signed [15:0] bias_reg;
   logic [14:0]       clamp_reg;

   pool_result_t pooled_expect_q [$];

   // Clamped ReLU output of one conv position, unsigned Q7.8.
   function automatic int conv_point(int row, int col, int st, int nch);
      longint acc;
      int     y;
      int     x;
      acc = longint'(bias_reg) * 256;
      for (int ch = 0; ch < nch; ch++) begin
         for (int ky = 0; ky < KERNEL; ky++) begin
            for (int kx = 0; kx < KERNEL; kx++) begin
               y = row * st + ky;
               x = col * st + kx;
               acc += longint'(kernel_mem[ch * KERNEL * KERNEL + ky * KERNEL + kx]) *
                      longint'(image_mem[ch * IMG_W * IMG_H + y * IMG_W + x]);
            end
         end
      end
      if (acc <= 0) return 0;
      if (acc > longint'(clamp_reg) * 256) return int'(clamp_reg);
      return int'(acc >>> 8);
   endfunction

   function automatic pool_result_t predict_pool(logic [IDX_W-1:0] pos);
      pool_result_t res;
      int st;
      int nch;
      int pw;
      int ph;
      int p;
      int best;
      int v;
      st  = (stride_reg == 0) ? 1 : (stride_reg > 4) ? 4 : int'(stride_reg);
      nch = (chan_reg == 0) ? 1 : (chan_reg > MAX_CHANNELS) ? MAX_CHANNELS : int'(chan_reg);
      pw  = ((IMG_W - KERNEL) / st + 1) / POOL;
      ph  = ((IMG_H - KERNEL) / st + 1) / POOL;
      p   = int'(pos);
      res.pooled     = '0;
      res.out_of_map = 1'b1;
      if (p >= pw * ph) return res;
      best = 0;
      for (int dy = 0; dy < POOL; dy++) begin
         for (int dx = 0; dx < POOL; dx++) begin
            v = conv_point((p / pw) * POOL + dy, (p % pw) * POOL + dx, st, nch);
            if (v > best) best = v;
         end
      end
      res.pooled     = OUT_W'(best);
      res.out_of_map = 1'b0;
      return res;
   endfunction

   always @(posedge clock) begin
      pool_result_t     want;
      logic [IDX_W-1:0] idx;
      if (reset) begin
         stride_reg = 3'd1;
         chan_reg   = 4'd1;
         bias_reg   = '0;
         clamp_reg  = 15'd2560;
         pooled_expect_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pooled_expect_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: response beat with no query open: expected none, actual %0d/%0b",
                        $time, rsp_tdata[OUT_W-1:0], rsp_tuser[0]);
            end else begin
               want = pooled_expect_q.pop_front();
               if (rsp_tdata[OUT_W-1:0] !== want.pooled) begin
                  mismatch_count++;
                  $display("%0t: pooled_value expected %0d actual %0d",
                           $time, want.pooled, rsp_tdata[OUT_W-1:0]);
               end
               if (rsp_tuser[0] !== want.out_of_map) begin
                  mismatch_count++;
                  $display("%0t: index_error expected %0b actual %0b",
                           $time, want.out_of_map, rsp_tuser[0]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            idx = req_tdata[IDX_W-1:0];
            case (req_tuser)
               MODE_WEIGHT: if (idx < WDEPTH) kernel_mem[idx] = req_tdata[IDX_W +: VAL_W];
               MODE_PIXEL:  if (idx < IDEPTH) image_mem[idx] = req_tdata[IDX_W +: VAL_W];
               MODE_QUERY:  pooled_expect_q.push_back(predict_pool(idx));
               default: ;
            endcase
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_STRIDE:   stride_reg = csr_wdata[2:0];
               CSR_CHANNELS: chan_reg   = csr_wdata[3:0];
               CSR_BIAS:     bias_reg   = csr_wdata;
               CSR_CLAMP:    clamp_reg  = csr_wdata[14:0];
            endcase
         end
      end
      pending_count = pooled_expect_q.size();
   end

endmodule

### verif/conv_relu_clamp_maxpool_tb.sv
// Top of the conv_relu_clamp_maxpool regression: clock, reset, load and query stimulus,
// response back-pressure and the verdict. Checking lives in crcm_pool_checker.
// Depends on crcm_pkg, conv_relu_clamp_maxpool and crcm_pool_checker.
module conv_relu_clamp_maxpool_tb
   import crcm_pkg::*;
;

   localparam logic [1:0] MODE_SPARE     = 2'd3;
   localparam int         BACKLOG_AT     = 40;
   localparam int         BACKLOG_CYCLES = 2000;
   localparam int         DRAIN_CYCLES   = 400;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // index[12:0], value[28:13], zero pad
   logic [1:0]  req_tuser;   // mode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // pooled_value[14:0], zero pad
   logic [0:0]  rsp_tuser;   // index_error[0]
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [15:0] csr_wdata;

   int mismatch_count;
   int pending_count;
   int req_calm;

   conv_relu_clamp_maxpool u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   crcm_pool_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Mostly a random idle gap before each beat, with occasional runs of back-to-back beats.
   function automatic int pick_gap(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(10, 40);
      return $urandom_range(0, 5);
   endfunction

   function automatic logic [VAL_W-1:0] fill_value();
      return VAL_W'($urandom_range(0, 1023) - 512);
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      if ($urandom_range(0, 3) == 0) return VAL_W'($urandom);
      return VAL_W'($urandom_range(0, 1535) - 768);
   endfunction

   function automatic int map_positions(logic [2:0] raw_stride);
      int st;
      st = (raw_stride == 0) ? 1 : (raw_stride > 4) ? 4 : int'(raw_stride);
      return (((IMG_W - KERNEL) / st + 1) / POOL) * (((IMG_H - KERNEL) / st + 1) / POOL);
   endfunction

   // Entered and left just after a falling edge.
   task automatic send_beat(input logic [1:0] mode, input logic [IDX_W-1:0] idx,
                            input logic [VAL_W-1:0] val);
      int gap;
      gap = pick_gap(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {3'b000, val, idx};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] addr, input logic [15:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [2:0] st, input logic [3:0] ch,
                                 input logic [15:0] bias, input logic [14:0] clamp);
      write_reg(CSR_STRIDE, 16'(st));
      write_reg(CSR_CHANNELS, 16'(ch));
      write_reg(CSR_BIAS, bias);
      write_reg(CSR_CLAMP, 16'(clamp));
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Drain all open queries, then give a trailing load time to land.
   task automatic settle();
      req_tvalid <= 1'b0;
      wait (pending_count == 0);
      repeat (16) @(negedge clock);
   endtask

   task automatic random_phase(input logic [2:0] st, input logic [3:0] ch,
                               input logic [15:0] bias, input logic [14:0] clamp,
                               input int items);
      int               positions;
      int               done;
      int               pick;
      logic [IDX_W-1:0] idx;
      settle();
      apply_settings(st, ch, bias, clamp);
      positions = map_positions(st);
      done = 0;
      while (done < items) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            case ($urandom_range(0, 9))
               0:       idx = IDX_W'(positions - 1 + $urandom_range(0, 1));
               1:       idx = IDX_W'($urandom);
               default: idx = IDX_W'($urandom_range(0, positions - 1));
            endcase
            send_beat(MODE_QUERY, idx, VAL_W'($urandom));
            done++;
         end else if (pick < 62) begin
            send_beat(MODE_WEIGHT, IDX_W'($urandom_range(0, WDEPTH - 1)), pick_value());
            done++;
         end else if (pick < 88) begin
            send_beat(MODE_PIXEL, IDX_W'($urandom_range(0, IDEPTH - 1)), pick_value());
            done++;
         end else if (pick < 92) begin
            // out-of-range loads must leave both stores untouched
            send_beat(MODE_WEIGHT, IDX_W'($urandom_range(WDEPTH, 8191)), VAL_W'($urandom));
         end else if (pick < 96) begin
            send_beat(MODE_PIXEL, IDX_W'($urandom_range(IDEPTH, 8191)), VAL_W'($urandom));
         end else begin
            send_beat(MODE_SPARE, IDX_W'($urandom), VAL_W'($urandom));
         end
      end
   endtask

   initial begin : response_side
      int gap;
      int calm_left;
      int beats;
      calm_left = 0;
      beats     = 0;
      @(negedge reset);
      @(negedge clock);
      forever begin
         gap = pick_gap(calm_left);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
         beats++;
         if (beats == BACKLOG_AT) begin
            // hold off long enough for the result register and the sequencer to fill
            rsp_tready <= 1'b0;
            repeat (BACKLOG_CYCLES) @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = MODE_WEIGHT;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = CSR_STRIDE;
      csr_wdata  = '0;
      req_calm   = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      apply_settings(3'd1, 4'd8, 16'h0000, 15'd2560);

      // write every store entry so no query reads an unwritten one
      for (int a = 0; a < WDEPTH; a++) send_beat(MODE_WEIGHT, IDX_W'(a), fill_value());
      for (int a = 0; a < IDEPTH; a++) send_beat(MODE_PIXEL, IDX_W'(a), fill_value());

      // field extremes, ignored loads, spare mode, map corners and first positions outside
      send_beat(MODE_WEIGHT, IDX_W'(0), 16'h8000);
      send_beat(MODE_WEIGHT, IDX_W'(WDEPTH - 1), 16'h7FFF);
      send_beat(MODE_PIXEL, IDX_W'(0), 16'h7FFF);
      send_beat(MODE_PIXEL, IDX_W'(IDEPTH - 1), 16'h8000);
      send_beat(MODE_WEIGHT, IDX_W'(WDEPTH), 16'h7FFF);
      send_beat(MODE_WEIGHT, 13'h1FFF, 16'h8000);
      send_beat(MODE_PIXEL, IDX_W'(IDEPTH), 16'h7FFF);
      send_beat(MODE_PIXEL, 13'h1FFF, 16'h8000);
      send_beat(MODE_SPARE, IDX_W'(0), 16'h7FFF);
      send_beat(MODE_QUERY, IDX_W'(0), 16'hFFFF);
      send_beat(MODE_QUERY, IDX_W'(map_positions(3'd1) - 1), 16'h0000);
      send_beat(MODE_QUERY, IDX_W'(map_positions(3'd1)), 16'h5555);
      send_beat(MODE_QUERY, 13'h1FFF, 16'hAAAA);

      // largest stride, channel count above the store, largest bias and clamp
      settle();
      apply_settings(3'd4, 4'd9, 16'h7FFF, 15'h7FFF);
      send_beat(MODE_QUERY, IDX_W'(map_positions(3'd4) - 1), 16'h0000);
      send_beat(MODE_QUERY, IDX_W'(map_positions(3'd4)), 16'h0000);
      send_beat(MODE_QUERY, IDX_W'(0), 16'h0000);

      // stride and channel count zero, most negative bias, clamp zero
      settle();
      apply_settings(3'd0, 4'd0, 16'h8000, 15'd0);
      send_beat(MODE_QUERY, IDX_W'(0), 16'h0000);
      send_beat(MODE_QUERY, IDX_W'(map_positions(3'd0) - 1), 16'h0000);
      send_beat(MODE_QUERY, IDX_W'(map_positions(3'd0)), 16'h0000);

      // stride above the top of the range, all channel bits set
      settle();
      apply_settings(3'd7, 4'd15, 16'h0100, 15'd2560);
      send_beat(MODE_QUERY, IDX_W'(4), 16'h0000);
      send_beat(MODE_QUERY, IDX_W'(map_positions(3'd7)), 16'h0000);

      random_phase(3'd1, 4'd8, 16'h0000, 15'd2560, 120);
      random_phase(3'd2, 4'd4, 16'hFE00, 15'd1280, 115);
      random_phase(3'd3, 4'd2, 16'h0300, 15'h7FFF, 115);
      random_phase(3'd5, 4'd12, VAL_W'($urandom), 15'($urandom), 115);
      random_phase(3'd0, 4'd1, 16'h0064, 15'd5000, 115);
      random_phase(3'($urandom_range(1, 4)), 4'($urandom_range(1, 8)),
                   VAL_W'($urandom_range(0, 1023) - 512), 15'($urandom_range(256, 8192)), 120);

      req_tvalid <= 1'b0;
      wait (pending_count == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("conv_relu_clamp_maxpool regression: pass");
      end else begin
         $display("conv_relu_clamp_maxpool regression: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #12_000_000;
      $display("conv_relu_clamp_maxpool regression: fail");
      $finish;
   end

endmodule
